// ===== hw/rtl/pcat_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcat_pkg;

  // Field widths
  localparam int TIME_W  = 32;
  localparam int LEVEL_W = 12;
  localparam int RPM_W   = 16;
  localparam int SHIFT_W = 5;
  localparam int PROD_W  = LEVEL_W + RPM_W;

  // Pedal level ceiling: the design limit, bounded by the level register width
  localparam int LEVEL_MAX = 4095;
  localparam int LEVEL_CAP = (LEVEL_MAX > (2 ** LEVEL_W) - 1) ? (2 ** LEVEL_W) - 1 : LEVEL_MAX;

  // Scaled speed saturation and low-pass filter geometry
  localparam int SPEED_W   = 15;
  localparam int SPEED_SAT = (2 ** SPEED_W) - 1;
  localparam int FILT_W    = RPM_W + 6;
  localparam int FILT_SH   = 6;

endpackage : pcat_pkg

`default_nettype wire

// ===== hw/rtl/pcat_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pcat_in_if import pcat_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [TIME_W-1:0] time_ms;

  modport source (output valid, output op, output time_ms, input ready);
  modport sink   (input valid, input op, input time_ms, output ready);
endinterface : pcat_in_if

`default_nettype wire

// ===== hw/rtl/pcat_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface pcat_out_if import pcat_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [RPM_W-1:0]   target_rpm;
  logic [LEVEL_W-1:0] pedal_level;
  logic               edge_accepted;

  modport source (output valid, output target_rpm, output pedal_level, output edge_accepted,
                  input ready);
  modport sink   (input valid, input target_rpm, input pedal_level, input edge_accepted,
                  output ready);
endinterface : pcat_out_if

`default_nettype wire

// ===== hw/rtl/pedal_cadence_assist_target.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake            Payload
// in_ch     in   valid/ready          op (0 edge, 1 tick), time_ms[31:0]
// out_ch    out  valid/ready          target_rpm[15:0], pedal_level[11:0], edge_accepted
// APB       in   psel/penable/pready  paddr[4:0] = 4*index, pwdata/prdata[31:0]
//
// An edge request passes through accept, evaluate and push before its result is loaded.
// A tick request passes through accept, evaluate, the bit-serial divider
// (elapsed / deramp_divisor), decay, the shift-add multiplier, filter and push.
// One request is in flight at a time; the next is taken as soon as its result is loaded.
// A result waiting in the output register does not block acceptance; the push stage
// holds only when the output register is still full. Reset (rst_n low, synchronous)
// clears the control state, pedal state and configuration registers to their defaults.
module pedal_cadence_assist_target import pcat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pcat_in_if.sink          in_ch,
  pcat_out_if.source       out_ch,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Register indexes
  localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
  localparam logic [2:0] REG_MAX_INTERVAL = 3'd1;
  localparam logic [2:0] REG_ADD_AMOUNT   = 3'd2;
  localparam logic [2:0] REG_DERAMP_DIV   = 3'd3;
  localparam logic [2:0] REG_SCALE_SHIFT  = 3'd4;
  localparam logic [2:0] REG_TIMEOUT      = 3'd5;
  localparam logic [2:0] REG_ASSIST_RPM   = 3'd6;
  localparam logic [2:0] REG_RPM_CEILING  = 3'd7;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_DECAY = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_FILT  = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  localparam logic [LEVEL_W:0] CAP_EXT = (LEVEL_W + 1)'(LEVEL_CAP);

  // Configuration registers
  logic [RPM_W-1:0]   min_interval_r, max_interval_r, deramp_div_r;
  logic [RPM_W-1:0]   timeout_r, assist_rpm_r, rpm_ceiling_r;
  logic [LEVEL_W-1:0] add_amount_r;
  logic [SHIFT_W-1:0] scale_shift_r;

  // Block state and request registers
  logic [2:0]         state_r, state_nxt;
  logic [TIME_W-1:0]  last_edge_r, last_edge_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [RPM_W-1:0]   target_r, target_nxt;
  logic               acc_r, acc_nxt;
  logic               op_r;
  logic [TIME_W-1:0]  time_r;
  logic [TIME_W-1:0]  elapsed_r;

  // Output register
  logic               out_valid_r;
  logic [RPM_W-1:0]   out_rpm_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic               out_acc_r;

  logic               in_fire, cfg_wr, push;
  logic [2:0]         cfg_idx;

  // Datapath
  logic [RPM_W-1:0]   clamp_diff;
  logic               edge_ok;
  logic [LEVEL_W:0]   level_sum;
  logic [RPM_W-1:0]   div_dvs;
  logic               div_start, div_done;
  logic [TIME_W-1:0]  quo;
  logic [LEVEL_W-1:0] level_decayed;
  logic               mul_start, mul_done;
  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  prod_sh;
  logic [SPEED_W-1:0] speed;
  logic [FILT_W-1:0]  filt_sum;
  logic [RPM_W-1:0]   filt;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign push        = (state_r == S_PUSH) && (!out_valid_r || out_ch.ready);

  // Edge: clamp the interval, then check against the minimum
  assign clamp_diff = (elapsed_r > {{(TIME_W - RPM_W){1'b0}}, max_interval_r}) ?
                      max_interval_r : elapsed_r[RPM_W-1:0];
  assign edge_ok    = (clamp_diff >= min_interval_r);
  assign level_sum  = {1'b0, level_r} + {1'b0, add_amount_r};

  // Tick: decay by elapsed / divisor (zero divisor acts as one)
  assign div_dvs   = (deramp_div_r == '0) ? RPM_W'(1) : deramp_div_r;
  assign div_start = (state_r == S_EVAL) && op_r;

  pcat_serdiv u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (elapsed_r),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  assign level_decayed = ({{(TIME_W - LEVEL_W){1'b0}}, level_r} > quo) ?
                         (level_r - quo[LEVEL_W-1:0]) : '0;
  assign mul_start     = (state_r == S_DECAY);

  // Feed the decayed level straight in; it lands in level_r on the same edge
  pcat_sermul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mplr    (level_decayed),
    .mcand   (assist_rpm_r),
    .done    (mul_done),
    .product (prod)
  );

  // Scale, saturate, force zero after timeout, then 30/34 over 64 low-pass
  assign prod_sh = prod >> scale_shift_r;

  always_comb begin
    if (prod_sh > PROD_W'(SPEED_SAT)) begin
      speed = SPEED_W'(SPEED_SAT);
    end else begin
      speed = prod_sh[SPEED_W-1:0];
    end
    if (elapsed_r > {{(TIME_W - RPM_W){1'b0}}, timeout_r}) begin
      speed = '0;
    end
  end

  // 30*s = 32*s - 2*s, 34*t = 32*t + 2*t
  assign filt_sum = ({{(FILT_W - SPEED_W){1'b0}}, speed} << 5)
                  - ({{(FILT_W - SPEED_W){1'b0}}, speed} << 1)
                  + ({{(FILT_W - RPM_W){1'b0}}, target_r} << 5)
                  + ({{(FILT_W - RPM_W){1'b0}}, target_r} << 1);
  assign filt     = filt_sum[FILT_SH +: RPM_W];

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    last_edge_nxt = last_edge_r;
    level_nxt     = level_r;
    target_nxt    = target_r;
    acc_nxt       = acc_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (op_r) begin
          acc_nxt   = 1'b0;
          state_nxt = S_DIV;
        end else begin
          acc_nxt   = edge_ok;
          state_nxt = S_PUSH;
          if (edge_ok) begin
            last_edge_nxt = time_r;
            level_nxt     = (level_sum > CAP_EXT) ? CAP_EXT[LEVEL_W-1:0] : level_sum[LEVEL_W-1:0];
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_DECAY;
        end
      end
      S_DECAY: begin
        level_nxt = level_decayed;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          state_nxt = S_FILT;
        end
      end
      S_FILT: begin
        target_nxt = (filt > rpm_ceiling_r) ? rpm_ceiling_r : filt;
        state_nxt  = S_PUSH;
      end
      S_PUSH: begin
        if (push) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_edge_r <= '0;
      level_r     <= '0;
      target_r    <= '0;
      acc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      last_edge_r <= last_edge_nxt;
      level_r     <= level_nxt;
      target_r    <= target_nxt;
      acc_r       <= acc_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and its elapsed time since the last accepted edge; load the output on push
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r      <= in_ch.op;
      time_r    <= in_ch.time_ms;
      elapsed_r <= in_ch.time_ms - last_edge_r;
    end
    if (push) begin
      out_rpm_r   <= target_r;
      out_level_r <= level_r;
      out_acc_r   <= acc_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.target_rpm    = out_rpm_r;
  assign out_ch.pedal_level   = out_level_r;
  assign out_ch.edge_accepted = out_acc_r;

  // Configuration writes; low address bits are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r <= '0;
      max_interval_r <= '1;
      add_amount_r   <= '0;
      deramp_div_r   <= RPM_W'(1);
      scale_shift_r  <= '0;
      timeout_r      <= '0;
      assist_rpm_r   <= '0;
      rpm_ceiling_r  <= '1;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MIN_INTERVAL: min_interval_r <= pwdata[RPM_W-1:0];
        REG_MAX_INTERVAL: max_interval_r <= pwdata[RPM_W-1:0];
        REG_ADD_AMOUNT:   add_amount_r   <= pwdata[LEVEL_W-1:0];
        REG_DERAMP_DIV:   deramp_div_r   <= pwdata[RPM_W-1:0];
        REG_SCALE_SHIFT:  scale_shift_r  <= pwdata[SHIFT_W-1:0];
        REG_TIMEOUT:      timeout_r      <= pwdata[RPM_W-1:0];
        REG_ASSIST_RPM:   assist_rpm_r   <= pwdata[RPM_W-1:0];
        REG_RPM_CEILING:  rpm_ceiling_r  <= pwdata[RPM_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MIN_INTERVAL: prdata = {16'd0, min_interval_r};
      REG_MAX_INTERVAL: prdata = {16'd0, max_interval_r};
      REG_ADD_AMOUNT:   prdata = {20'd0, add_amount_r};
      REG_DERAMP_DIV:   prdata = {16'd0, deramp_div_r};
      REG_SCALE_SHIFT:  prdata = {27'd0, scale_shift_r};
      REG_TIMEOUT:      prdata = {16'd0, timeout_r};
      REG_ASSIST_RPM:   prdata = {16'd0, assist_rpm_r};
      REG_RPM_CEILING:  prdata = {16'd0, rpm_ceiling_r};
      default:          prdata = '0;
    endcase
  end

  // A result appears only out of the push stage
  a_push_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_PUSH))
    else $error("output loaded outside push stage");

  // The pedal level never passes its ceiling
  a_level_cap: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, level_r} <= CAP_EXT)
    else $error("pedal level above ceiling");

  // Serial units finish only while the sequencer waits on them
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_MUL))
    else $error("multiplier finished outside its wait state");

  // An edge request never moves the target speed
  a_edge_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && !op_r) |=> $stable(target_r))
    else $error("edge request changed target speed");

endmodule : pedal_cadence_assist_target

`default_nettype wire

// ===== hw/rtl/pcat_serdiv.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle, MSB first.
module pcat_serdiv import pcat_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TIME_W-1:0] dividend,
  input  wire logic [RPM_W-1:0]  divisor,
  output logic                   done,
  output logic [TIME_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(TIME_W);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RPM_W-1:0]  rem_r, rem_nxt;
  logic [RPM_W-1:0]  dvs_r;
  logic [TIME_W-1:0] quo_r, quo_nxt;
  logic [RPM_W:0]    trial;
  logic [RPM_W:0]    diff;
  logic              ge;

  // Shift the dividend out at the top while quotient bits enter at the bottom
  assign trial = {rem_r, quo_r[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = ~diff[RPM_W];
  assign done  = busy_r && (cnt_r == CNT_W'(TIME_W - 1));
  assign quotient = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[RPM_W-1:0] : trial[RPM_W-1:0];
      quo_nxt = {quo_r[TIME_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

endmodule : pcat_serdiv

`default_nettype wire

// ===== hw/rtl/pcat_sermul.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, LSB first.
module pcat_sermul import pcat_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [LEVEL_W-1:0] mplr,
  input  wire logic [RPM_W-1:0]   mcand,
  output logic                    done,
  output logic [PROD_W-1:0]       product
);

  localparam int CNT_W = $clog2(LEVEL_W);

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [RPM_W-1:0]  mcand_r;
  logic [PROD_W-1:0] p_r, p_nxt;
  logic [RPM_W:0]    upper;

  // Add into the upper half, then shift the whole product right
  assign upper   = {1'b0, p_r[PROD_W-1:LEVEL_W]} + (p_r[0] ? {1'b0, mcand_r} : '0);
  assign done    = busy_r && (cnt_r == CNT_W'(LEVEL_W - 1));
  assign product = p_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    p_nxt    = p_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      p_nxt    = {{RPM_W{1'b0}}, mplr};
    end else if (busy_r) begin
      p_nxt   = {upper, p_r[LEVEL_W-1:1]};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (done) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
    if (start) begin
      mcand_r <= mcand;
    end
  end

endmodule : pcat_sermul

`default_nettype wire
